// ===== src/rtil_pkg.sv =====
// Package for the relation table block: action and status codes and the
// token that travels down the row of table cells. No dependencies.
package rtil_pkg;

    localparam int ADDR_W = 48;
    localparam int ID_W   = 32;

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // One request in flight through the cell row, with what it has learned so far.
    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] hw_address;
        logic [ID_W-1:0]   link_id;
        logic              hit;
        logic              appended;
        logic [ADDR_W-1:0] found_address;
    } rtil_token_t;

endpackage

// ===== src/rtil_cell.sv =====
// One table cell: holds a single address and identifier pair and passes the
// request token on to its neighbor in the next cycle. Depends on rtil_pkg.
module rtil_cell
    import rtil_pkg::*;
#(
    parameter int CELL_INDEX = 0,
    parameter int CNT_W      = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] fill_count,
    input  logic             tok_valid_in,
    input  rtil_token_t      tok_in,
    output logic             tok_valid_out,
    output rtil_token_t      tok_out
);

    logic [ADDR_W-1:0] addr_reg;
    logic [ID_W-1:0]   id_reg;
    logic              valid_reg;
    rtil_token_t       tok_reg;
    rtil_token_t       tok_next;
    logic              write_en;
    logic              filled;
    logic              at_end;

    assign filled = CNT_W'(CELL_INDEX) < fill_count;
    assign at_end = CNT_W'(CELL_INDEX) == fill_count;

    // An entry at or past the fill count is never compared; the first empty
    // cell takes an add that found no duplicate in the cells before it.
    always_comb
    begin
        tok_next = tok_in;
        write_en = 1'b0;
        if (tok_valid_in && !tok_in.hit && !tok_in.appended)
        begin
            if (tok_in.action == ACT_ADD)
            begin
                if (filled && addr_reg == tok_in.hw_address)
                begin
                    tok_next.hit = 1'b1;
                end
                else if (at_end)
                begin
                    tok_next.appended = 1'b1;
                    write_en          = 1'b1;
                end
            end
            else if (filled && id_reg == tok_in.link_id)
            begin
                tok_next.hit           = 1'b1;
                tok_next.found_address = addr_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tok_valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (write_en)
        begin
            addr_reg <= tok_in.hw_address;
            id_reg   <= tok_in.link_id;
        end
    end

    assign tok_valid_out = valid_reg;
    assign tok_out       = tok_reg;

endmodule

// ===== src/relation_table_insert_lookup.sv =====
// Top level of the relation table: a row of MAX_ENTRIES cells, the fill count
// and the result register. Depends on rtil_pkg and rtil_cell.
//
// Usage: an item is accepted at a rising edge where start is high and busy is
// low. The item carries action (add or lookup), hw_address and link_id.
// Exactly one result beat follows each item: done is high for one cycle while
// status and found_address hold the result. The receiver cannot stall, so the
// result must be captured in that cycle.
//
// The accepted request enters cell 0 at the accepting edge and moves one cell
// per clock down the row, each cell comparing it against the pair it holds.
// An add is written into the first empty cell, right after all filled cells
// have been checked for a duplicate address. A lookup picks up the address of
// the first cell whose identifier matches. After the last cell, the result
// register forms the status.
//
// Done rises and busy drops in the same cycle, so a new item can be accepted
// while done is high. One item is in flight at a time. Reset empties the table
// (fill count to zero) and clears busy and done; the stored pairs themselves
// are not cleared.
module relation_table_insert_lookup
    import rtil_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              action,
    input  logic [ADDR_W-1:0] hw_address,
    input  logic [ID_W-1:0]   link_id,
    output logic              done,
    output logic [1:0]        status,
    output logic [ADDR_W-1:0] found_address
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic                  accept;
    logic                  busy_reg;
    logic                  busy_next;
    logic [CNT_W-1:0]      fill_count_reg;
    logic [CNT_W-1:0]      fill_count_next;
    logic                  done_reg;
    logic [1:0]            status_reg;
    logic [1:0]            status_next;
    logic [ADDR_W-1:0]     found_address_reg;
    logic                  chain_valid [MAX_ENTRIES+1];
    rtil_token_t           chain_tok   [MAX_ENTRIES+1];
    logic                  last_valid;
    rtil_token_t           last_tok;

    assign accept = start && !busy_reg;

    // The head of the row sees the request straight from the ports.
    assign chain_valid[0] = accept;
    assign chain_tok[0]   = '{action:        action,
                              hw_address:    hw_address,
                              link_id:       link_id,
                              hit:           1'b0,
                              appended:      1'b0,
                              found_address: '0};

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        rtil_cell #(
            .CELL_INDEX (g),
            .CNT_W      (CNT_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .fill_count    (fill_count_reg),
            .tok_valid_in  (chain_valid[g]),
            .tok_in        (chain_tok[g]),
            .tok_valid_out (chain_valid[g+1]),
            .tok_out       (chain_tok[g+1])
        );
    end

    assign last_valid = chain_valid[MAX_ENTRIES];
    assign last_tok   = chain_tok[MAX_ENTRIES];

    // Busy covers the whole trip through the row; the exit beat frees the block.
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (last_valid)
        begin
            busy_next = 1'b0;
        end
    end

    // The count moves only once the request leaves the row, so every cell saw
    // the same fill count while it passed.
    always_comb
    begin
        fill_count_next = fill_count_reg;
        if (last_valid && last_tok.action == ACT_ADD && last_tok.appended)
        begin
            fill_count_next = fill_count_reg + CNT_W'(1);
        end
    end

    // A duplicate outranks a full table, since the duplicate scan comes first.
    always_comb
    begin
        priority if (last_tok.action == ACT_ADD && last_tok.hit)
        begin
            status_next = ST_DUPLICATE;
        end
        else if (last_tok.action == ACT_ADD && !last_tok.appended)
        begin
            status_next = ST_FULL;
        end
        else if (last_tok.action == ACT_LOOKUP && !last_tok.hit)
        begin
            status_next = ST_NOT_FOUND;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            fill_count_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            fill_count_reg <= fill_count_next;
            done_reg       <= last_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_valid)
        begin
            status_reg        <= status_next;
            found_address_reg <= last_tok.found_address;
        end
    end

    assign busy          = busy_reg;
    assign done          = done_reg;
    assign status        = status_reg;
    assign found_address = found_address_reg;

endmodule

// ===== src/rtil_checker.sv =====
// Port-level checker for the relation table, bound to the top level.
// Depends on rtil_pkg.
module rtil_checker
    import rtil_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic [1:0]        status,
    input logic [ADDR_W-1:0] found_address
);

    // An accepted beat keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("block not busy after accepting a beat");

    // The result beat comes only once the block has finished the item.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while still busy");

    // Only one item is in flight, so result beats never come back to back.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two result beats in a row");

    // An address is returned only with a successful status.
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> found_address == '0)
        else $error("nonzero address on an unsuccessful result");

    // Busy rises only when a start beat was offered in the cycle before.
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !busy ##1 busy |-> $past(start))
        else $error("busy rose without a start beat");

endmodule

bind relation_table_insert_lookup rtil_checker u_rtil_checker (.*);
